FILE: design/wfks_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint follower package
// Shared constants, codes, sequencer types and heading helpers.
// ----------------------------------------------------------------------------
package wfks_pkg;

   localparam int MAX_WAYPOINTS_DEF = 256;
   localparam int CORDIC_STEPS_DEF  = 16;
   localparam int POS_FRAC_BITS_DEF = 16;

   // Wide enough for any table depth in the supported range.
   localparam int CNT_W = 13;

   localparam logic [2:0] CSR_SPEED         = 3'd0;
   localparam logic [2:0] CSR_STEP_DT       = 3'd1;
   localparam logic [2:0] CSR_MAX_TURN_RATE = 3'd2;
   localparam logic [2:0] CSR_LANE_WIDTH    = 3'd3;
   localparam logic [2:0] CSR_WP_COUNT      = 3'd4;
   localparam logic [2:0] CSR_START_X       = 3'd5;
   localparam logic [2:0] CSR_START_Y       = 3'd6;
   localparam logic [2:0] CSR_START_HEADING = 3'd7;

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_TICK    = 2'd1;
   localparam logic [1:0] FUNC_RESTART = 2'd2;

   localparam logic signed [17:0] PI_Q13     = 18'sd25736;
   localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;

   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;

   typedef enum logic [1:0] {
      ST_MOVED,
      ST_ADVANCED,
      ST_NO_TARGET,
      ST_ACK
   } rsp_status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_LOAD,
      OP_RESTART,
      OP_FETCH,
      OP_STEPMUL,
      OP_DIFF,
      OP_SQSTEP,
      OP_SQDX,
      OP_SQDY,
      OP_NEAR,
      OP_ADVANCE,
      OP_LIMMUL,
      OP_HEAD,
      OP_CINIT,
      OP_CITER,
      OP_MULC,
      OP_ADDX,
      OP_ADDY
   } dp_op_type;

   typedef struct packed {
      dp_op_type      op;
      logic           publish;
      rsp_status_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic no_target;
      logic advance;
      logic cordic_done;
   } dp_stat_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOAD,
      S_RESTART,
      S_FETCH,
      S_STEPMUL,
      S_DIFF,
      S_SQSTEP,
      S_SQDX,
      S_SQDY,
      S_NEAR,
      S_DECIDE,
      S_ADVANCE,
      S_LIMMUL,
      S_HEAD,
      S_CINIT,
      S_CITER,
      S_ADDX,
      S_ADDY,
      S_FINISH
   } ctrl_state_type;

   // One correction step brings any value used here back into [-pi, pi].
   function automatic logic signed [17:0] wrap_heading(input logic signed [17:0] h);
      logic signed [17:0] r;
      begin
         r = h;
         if (h > PI_Q13) begin
            r = h - TWO_PI_Q13;
         end else if (h < -PI_Q13) begin
            r = h + TWO_PI_Q13;
         end
         return r;
      end
   endfunction

   function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
      logic signed [33:0] r;
      begin
         unique case (i)
            5'd0:    r = 34'sd843314857;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043837;
            5'd3:    r = 34'sd133525159;
            5'd4:    r = 34'sd67021687;
            5'd5:    r = 34'sd33543516;
            5'd6:    r = 34'sd16775851;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194283;
            5'd9:    r = 34'sd2097149;
            5'd10:   r = 34'sd1048576;
            5'd11:   r = 34'sd524288;
            5'd12:   r = 34'sd262144;
            5'd13:   r = 34'sd131072;
            5'd14:   r = 34'sd65536;
            5'd15:   r = 34'sd32768;
            5'd16:   r = 34'sd16384;
            5'd17:   r = 34'sd8192;
            5'd18:   r = 34'sd4096;
            5'd19:   r = 34'sd2048;
            5'd20:   r = 34'sd1024;
            5'd21:   r = 34'sd512;
            5'd22:   r = 34'sd256;
            5'd23:   r = 34'sd128;
            default: r = 34'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

FILE: design/wfks_ctrl.sv
// ----------------------------------------------------------------------------
// Waypoint follower controller
// Sequences the datapath through load, restart and tick items.
// ----------------------------------------------------------------------------
module wfks_ctrl
   import wfks_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   rsp_status_type code_ff, code_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         code_ff      <= ST_ACK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd.op       = OP_NONE;
      cmd.publish  = 1'b0;
      cmd.code     = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op = OP_LATCH;
               unique case (req_func)
                  FUNC_LOAD:    state_in = S_LOAD;
                  FUNC_TICK:    state_in = S_FETCH;
                  FUNC_RESTART: state_in = S_RESTART;
                  default: begin
                     code_in  = ST_NO_TARGET;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_LOAD: begin
            cmd.op   = OP_LOAD;
            code_in  = ST_ACK;
            state_in = S_FINISH;
         end
         S_RESTART: begin
            cmd.op   = OP_RESTART;
            code_in  = ST_ACK;
            state_in = S_FINISH;
         end
         S_FETCH: begin
            if (stat.no_target) begin
               code_in  = ST_NO_TARGET;
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_FETCH;
               state_in = S_STEPMUL;
            end
         end
         S_STEPMUL: begin
            cmd.op   = OP_STEPMUL;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = S_SQSTEP;
         end
         S_SQSTEP: begin
            cmd.op   = OP_SQSTEP;
            state_in = S_SQDX;
         end
         S_SQDX: begin
            cmd.op   = OP_SQDX;
            state_in = S_SQDY;
         end
         S_SQDY: begin
            cmd.op   = OP_SQDY;
            state_in = S_NEAR;
         end
         S_NEAR: begin
            cmd.op   = OP_NEAR;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = stat.advance ? S_ADVANCE : S_LIMMUL;
         end
         S_ADVANCE: begin
            cmd.op   = OP_ADVANCE;
            code_in  = ST_ADVANCED;
            state_in = S_FINISH;
         end
         S_LIMMUL: begin
            cmd.op   = OP_LIMMUL;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            cmd.op   = OP_HEAD;
            state_in = S_CINIT;
         end
         S_CINIT: begin
            cmd.op   = OP_CINIT;
            state_in = S_CITER;
         end
         S_CITER: begin
            if (stat.cordic_done) begin
               cmd.op   = OP_MULC;
               state_in = S_ADDX;
            end else begin
               cmd.op = OP_CITER;
            end
         end
         S_ADDX: begin
            cmd.op   = OP_ADDX;
            state_in = S_ADDY;
         end
         S_ADDY: begin
            cmd.op   = OP_ADDY;
            code_in  = ST_MOVED;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // The result register is free once its previous beat is taken.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: design/wfks_dp.sv
// ----------------------------------------------------------------------------
// Waypoint follower datapath
// Registers, waypoint memory, shared multiplier and iterative CORDIC.
// ----------------------------------------------------------------------------
module wfks_dp
   import wfks_pkg::*;
#(
   parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
   parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
   parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_addr,
   input  logic [31:0]        csr_wdata,
   input  logic [7:0]         req_wp_index,
   input  logic signed [31:0] req_wp_x,
   input  logic signed [31:0] req_wp_y,
   input  logic signed [15:0] req_wp_heading,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [15:0] rsp_pos_heading,
   output logic               rsp_lane,
   output logic [8:0]         rsp_target_index,
   output logic [1:0]         rsp_status
);

   localparam int AW         = $clog2(MAX_WAYPOINTS);
   localparam int IW         = $clog2(CORDIC_STEPS + 1);
   localparam int STEP_SHIFT = 24 - POS_FRAC_BITS;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WAYPOINTS);

   // Configuration registers.
   logic [15:0]        speed_ff, step_dt_ff;
   logic [14:0]        turn_rate_ff;
   logic [30:0]        lane_width_ff;
   logic [8:0]         wp_count_ff;
   logic signed [31:0] start_x_ff, start_y_ff;
   logic signed [15:0] start_heading_ff;

   // Latched request.
   logic [7:0]         idx_ff;
   logic signed [31:0] in_x_ff, in_y_ff;
   logic signed [15:0] in_h_ff;

   // Pose state.
   logic signed [31:0] cur_x_ff, cur_y_ff;
   logic signed [15:0] cur_h_ff;
   logic [8:0]         target_ff;
   logic               lane_ff;

   // Working registers.
   logic [79:0]        mem [MAX_WAYPOINTS];
   logic [79:0]        rd_ff;
   logic signed [65:0] mul_ff, mul_in;
   logic [31:0]        step_ff;
   logic [24:0]        dx_ff, dy_ff;
   logic               close_ok_ff;
   logic [63:0]        ss_ff;
   logic [49:0]        acc_ff;
   logic               near_ff;
   logic signed [17:0] diff_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic               neg_ff;
   logic [IW-1:0]      iter_ff;

   logic [CNT_W-1:0]   n_cnt, tgt_ext;
   logic [31:0]        idx32, tgt32;
   logic               idx_ok;

   assign n_cnt   = (CNT_W'(wp_count_ff) > MAX_CNT) ? MAX_CNT : CNT_W'(wp_count_ff);
   assign tgt_ext = CNT_W'(target_ff);
   assign idx32   = 32'(idx_ff);
   assign tgt32   = 32'(target_ff);
   assign idx_ok  = (CNT_W'(idx_ff) < MAX_CNT);

   assign stat.no_target   = (tgt_ext >= n_cnt);
   assign stat.advance     = near_ff && ((tgt_ext + CNT_W'(1)) < n_cnt);
   assign stat.cordic_done = (iter_ff == IW'(CORDIC_STEPS));

   // Shared multiplier operand selection.
   logic signed [32:0] mul_a, mul_b;
   logic signed [33:0] cos_v, sin_v;

   assign cos_v = neg_ff ? -x_ff : x_ff;
   assign sin_v = neg_ff ? -y_ff : y_ff;

   always_comb begin
      mul_a = 33'sd0;
      mul_b = 33'sd0;
      unique case (cmd.op)
         OP_STEPMUL: begin
            mul_a = 33'(speed_ff);
            mul_b = 33'(step_dt_ff);
         end
         OP_SQSTEP: begin
            mul_a = 33'(step_ff);
            mul_b = 33'(step_ff);
         end
         OP_SQDX: begin
            mul_a = 33'(dx_ff);
            mul_b = 33'(dx_ff);
         end
         OP_SQDY: begin
            mul_a = 33'(dy_ff);
            mul_b = 33'(dy_ff);
         end
         OP_LIMMUL: begin
            mul_a = 33'(turn_rate_ff);
            mul_b = 33'(step_dt_ff);
         end
         OP_MULC: begin
            mul_a = 33'(step_ff);
            mul_b = cos_v[32:0];
         end
         OP_ADDX: begin
            mul_a = 33'(step_ff);
            mul_b = sin_v[32:0];
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
      mul_in = mul_a * mul_b;
   end

   // Distance terms from the fetched waypoint.
   logic signed [32:0] dxs, dys;
   logic [32:0]        dxa, dya;
   assign dxs = 33'(signed'(rd_ff[79:48])) - 33'(cur_x_ff);
   assign dys = 33'(signed'(rd_ff[47:16])) - 33'(cur_y_ff);
   assign dxa = dxs[32] ? 33'(-dxs) : 33'(dxs);
   assign dya = dys[32] ? 33'(-dys) : 33'(dys);

   logic [52:0] dist4;
   assign dist4 = {(51'(acc_ff) + 51'(mul_ff[49:0])), 2'b00};

   // Heading update.
   logic signed [17:0] herr, lim_s, clamped, hsum, hnew;
   assign herr    = wrap_heading(18'(signed'(rd_ff[15:0])) - 18'(cur_h_ff));
   assign lim_s   = signed'({3'b000, mul_ff[30:16]});
   assign clamped = (diff_ff > lim_s) ? lim_s : ((diff_ff < -lim_s) ? -lim_s : diff_ff);
   assign hsum    = 18'(cur_h_ff) + clamped;
   assign hnew    = wrap_heading(hsum);

   // CORDIC angle fold into [-pi/2, pi/2].
   logic signed [33:0] z0;
   assign z0 = signed'({cur_h_ff[15], cur_h_ff, 17'd0});

   logic signed [33:0] xs, ys, atn;
   assign xs  = x_ff >>> iter_ff;
   assign ys  = y_ff >>> iter_ff;
   assign atn = atan_q30(5'(iter_ff));

   // Position moves with saturation.
   logic signed [35:0] move, psum_x, psum_y;
   logic signed [31:0] new_x, new_y;
   assign move   = mul_ff[65:30];
   assign psum_x = 36'(cur_x_ff) + move;
   assign psum_y = 36'(cur_y_ff) + move;

   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      begin
         if (v > 36'sd2147483647) begin
            r = 32'sh7FFFFFFF;
         end else if (v < -36'sd2147483648) begin
            r = 32'sh80000000;
         end else begin
            r = v[31:0];
         end
         return r;
      end
   endfunction

   assign new_x = sat32(psum_x);
   assign new_y = sat32(psum_y);

   logic signed [33:0] y2, lw_s;
   assign y2   = {new_y[31], new_y, 1'b0};
   assign lw_s = signed'({3'b000, lane_width_ff});

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff         <= 16'd0;
         step_dt_ff       <= 16'd6554;
         turn_rate_ff     <= 15'd4096;
         lane_width_ff    <= 31'd458752;
         wp_count_ff      <= 9'd0;
         start_x_ff       <= 32'sd0;
         start_y_ff       <= 32'sd0;
         start_heading_ff <= 16'sd0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_SPEED:         speed_ff         <= csr_wdata[15:0];
            CSR_STEP_DT:       step_dt_ff       <= csr_wdata[15:0];
            CSR_MAX_TURN_RATE: turn_rate_ff     <= csr_wdata[14:0];
            CSR_LANE_WIDTH:    lane_width_ff    <= csr_wdata[30:0];
            CSR_WP_COUNT:      wp_count_ff      <= csr_wdata[8:0];
            CSR_START_X:       start_x_ff       <= signed'(csr_wdata);
            CSR_START_Y:       start_y_ff       <= signed'(csr_wdata);
            CSR_START_HEADING: start_heading_ff <= signed'(csr_wdata[15:0]);
            default:           ;
         endcase
      end
   end

   // Waypoint memory.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD && idx_ok) begin
         mem[idx32[AW-1:0]] <= {in_x_ff, in_y_ff, in_h_ff};
      end
      if (cmd.op == OP_FETCH) begin
         rd_ff <= mem[tgt32[AW-1:0]];
      end
   end

   // Pose state.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= 32'sd0;
         cur_y_ff  <= 32'sd0;
         cur_h_ff  <= 16'sd0;
         target_ff <= 9'd0;
         lane_ff   <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_RESTART: begin
               cur_x_ff  <= start_x_ff;
               cur_y_ff  <= start_y_ff;
               cur_h_ff  <= 16'(wrap_heading(18'(start_heading_ff)));
               target_ff <= 9'd0;
            end
            OP_ADVANCE: target_ff <= target_ff + 9'd1;
            OP_HEAD:    cur_h_ff  <= 16'(hnew);
            OP_ADDX:    cur_x_ff  <= new_x;
            OP_ADDY: begin
               cur_y_ff <= new_y;
               lane_ff  <= (y2 < lw_s) ? 1'b0 : 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Working registers and CORDIC iterations.
   always_ff @(posedge clock) begin
      mul_ff <= mul_in;
      if (cmd.op == OP_CINIT) begin
         iter_ff <= '0;
      end else if (cmd.op == OP_CITER) begin
         iter_ff <= iter_ff + IW'(1);
      end
      unique case (cmd.op)
         OP_LATCH: begin
            idx_ff  <= req_wp_index;
            in_x_ff <= req_wp_x;
            in_y_ff <= req_wp_y;
            in_h_ff <= req_wp_heading;
         end
         OP_DIFF: begin
            step_ff     <= 32'(mul_ff[31:0] >> STEP_SHIFT);
            dx_ff       <= dxa[24:0];
            dy_ff       <= dya[24:0];
            close_ok_ff <= (dxa < 33'd33554432) && (dya < 33'd33554432);
         end
         OP_SQDX: ss_ff  <= mul_ff[63:0];
         OP_SQDY: acc_ff <= mul_ff[49:0];
         OP_NEAR: near_ff <= close_ok_ff && (64'(dist4) < ss_ff);
         OP_LIMMUL: diff_ff <= herr;
         OP_CINIT: begin
            x_ff <= CORDIC_K;
            y_ff <= 34'sd0;
            if (z0 > HALF_PI_Q30) begin
               z_ff   <= z0 - PI_Q30;
               neg_ff <= 1'b1;
            end else if (z0 < -HALF_PI_Q30) begin
               z_ff   <= z0 + PI_Q30;
               neg_ff <= 1'b1;
            end else begin
               z_ff   <= z0;
               neg_ff <= 1'b0;
            end
         end
         OP_CITER: begin
            if (!z_ff[33]) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atn;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atn;
            end
         end
         default: ;
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_pos_x        <= cur_x_ff;
         rsp_pos_y        <= cur_y_ff;
         rsp_pos_heading  <= cur_h_ff;
         rsp_lane         <= lane_ff;
         rsp_target_index <= target_ff;
         rsp_status       <= cmd.code;
      end
   end

endmodule

FILE: design/waypoint_follow_kinematic_step_core.sv
// ----------------------------------------------------------------------------
// Waypoint follower step core
// Follows a table of waypoints one tick at a time with a CORDIC heading step.
// ----------------------------------------------------------------------------
//  port group | direction | handshake            | contents
//  req_*      | in        | req_valid/req_ready  | func, waypoint slot and pose
//  rsp_*      | out       | rsp_valid/rsp_ready  | pose, lane, target, status
//  csr_*      | in        | csr_we               | register index and data
//
// Load and restart items update the table or pose and then publish; unknown
// items publish at once. A tick ends early with no target or on an advance,
// and a moving tick runs the one-step-per-cycle CORDIC. One item is in work
// at a time; the next is accepted while the previous result beat still waits.
// Synchronous reset clears the pose and the target and restores register defaults.
// ----------------------------------------------------------------------------
module waypoint_follow_kinematic_step_core
   import wfks_pkg::*;
#(
   parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF,
   parameter int CORDIC_STEPS  = CORDIC_STEPS_DEF,
   parameter int POS_FRAC_BITS = POS_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_addr,
   input  logic [31:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [7:0]         req_wp_index,
   input  logic signed [31:0] req_wp_x,
   input  logic signed [31:0] req_wp_y,
   input  logic signed [15:0] req_wp_heading,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [15:0] rsp_pos_heading,
   output logic               rsp_lane,
   output logic [8:0]         rsp_target_index,
   output logic [1:0]         rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   wfks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wfks_dp #(
      .MAX_WAYPOINTS (MAX_WAYPOINTS),
      .CORDIC_STEPS  (CORDIC_STEPS),
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata),
      .req_wp_index     (req_wp_index),
      .req_wp_x         (req_wp_x),
      .req_wp_y         (req_wp_y),
      .req_wp_heading   (req_wp_heading),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_heading  (rsp_pos_heading),
      .rsp_lane         (rsp_lane),
      .rsp_target_index (rsp_target_index),
      .rsp_status       (rsp_status)
   );

endmodule
